[rtl/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, codes and types of the ray/sphere intersection core.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Field widths
  localparam int COORD_W    = 32;   // signed fixed-point coordinate
  localparam int RAD_W      = 31;   // unsigned radius
  localparam int V_W        = 33;   // origin minus center
  localparam int A_W        = 64;   // a = D.D, unsigned
  localparam int H_W        = 66;   // h = D.V, signed
  localparam int C_W        = 67;   // c = V.V - R*R, signed
  localparam int DV_W       = 65;   // one D*V product
  localparam int VV_W       = 66;   // one V*V product
  localparam int RR_W       = 62;   // R*R
  localparam int PP_W       = 66;   // partial products of h*h and a*c
  localparam int DISC_W     = 133;  // discriminant, signed
  localparam int RADICAND_W = 132;  // square root input, even width
  localparam int ROOT_W     = RADICAND_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 4;
  localparam int NUM_W      = 68;   // root numerator, signed
  localparam int NUMU_W     = 67;   // root numerator once known positive
  localparam int MP_W       = 65;   // one quotient limb times a direction

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic [RAD_W-1:0]          RADIUS_RESET = 31'd65536;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] org;
    logic [2:0][COORD_W-1:0] dir;
  } ray_t;

  // Data that rides along the long pipeline sections
  typedef struct packed {
    ray_t           ray;
    logic [A_W-1:0] a;
    logic [H_W-1:0] h;
    logic           miss;
  } side_t;

endpackage

[rtl/ray_sphere_intersect_core.sv]
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Ray/sphere intersection in fixed point: hit flag and nearest hit point
// past t = 1, fully pipelined.
// ----------------------------------------------------------------------------
// One ray transaction enters per clock unless in_stall is high. The pipeline
// depth is set by the 66-stage square root of the discriminant and the
// (67 + FRAC_BITS)-stage restoring divider that forms t, plus eleven stages
// of products, sums and the final hit-point multiply. Back-pressure on
// the result channel freezes the whole
// pipeline and shows on in_stall in the same cycle. The sphere center and
// radius are written through the cfg port, which is always ready, and must
// only be changed while no ray is in flight. A miss (zero direction,
// negative discriminant, or no root beyond t = 1) returns hit = 0 and a zero
// point; hit coordinates saturate to the signed 32-bit range.
module ray_sphere_intersect_core
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // ray input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  in_origin_x,
  input  logic signed [COORD_W-1:0]  in_origin_y,
  input  logic signed [COORD_W-1:0]  in_origin_z,
  input  logic signed [COORD_W-1:0]  in_dir_x,
  input  logic signed [COORD_W-1:0]  in_dir_y,
  input  logic signed [COORD_W-1:0]  in_dir_z,
  // result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic signed [COORD_W-1:0]  out_hit_x,
  output logic signed [COORD_W-1:0]  out_hit_y,
  output logic signed [COORD_W-1:0]  out_hit_z,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]         cfg_data
);

  localparam int QW   = NUMU_W + FRAC_BITS;      // quotient bits of t
  localparam int QL   = (QW + 31) / 32;          // 32-bit limbs of t
  localparam int PW   = QL * 32 + 33;            // t * dir product width
  localparam int SQ_N = ROOT_W;
  localparam int LAT  = 6 + SQ_N + 2 + QW + 3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] cen_r [3];
  logic [RAD_W-1:0]   radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: cen_r[0] <= cfg_data;
        CFG_CENTER_Y: cen_r[1] <= cfg_data;
        CFG_CENTER_Z: cen_r[2] <= cfg_data;
        CFG_RADIUS:   radius_r <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: one enable, valid bits shift with the data
  // --------------------------------------------------------------------------
  logic           en;
  logic           in_acc;
  logic [LAT-1:0] vld_r;

  assign out_valid = vld_r[LAT-1];
  assign in_stall  = out_valid && out_stall;
  assign en        = !in_stall;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_acc};
    end
  end

  // --------------------------------------------------------------------------
  // S1: capture ray, V = O - C
  // --------------------------------------------------------------------------
  ray_t                  in_ray;
  ray_t                  s1_ray_r;
  logic signed [V_W-1:0] s1_v_r [3];

  always_comb begin
    in_ray.org[0] = in_origin_x;
    in_ray.org[1] = in_origin_y;
    in_ray.org[2] = in_origin_z;
    in_ray.dir[0] = in_dir_x;
    in_ray.dir[1] = in_dir_y;
    in_ray.dir[2] = in_dir_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ray_r <= in_ray;
      for (int k = 0; k < 3; k++) begin
        s1_v_r[k] <= V_W'($signed(in_ray.org[k])) - V_W'($signed(cen_r[k]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // S2: dot-product terms and R*R
  // --------------------------------------------------------------------------
  logic signed [A_W-1:0]  dd   [3];
  logic signed [DV_W-1:0] dv   [3];
  logic signed [VV_W-1:0] vv   [3];
  logic [RR_W-1:0]        rr;
  ray_t                   s2_ray_r;
  logic [A_W-1:0]         s2_dd_r [3];
  logic signed [DV_W-1:0] s2_dv_r [3];
  logic signed [VV_W-1:0] s2_vv_r [3];
  logic [RR_W-1:0]        s2_rr_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd[k] = $signed(s1_ray_r.dir[k]) * $signed(s1_ray_r.dir[k]);
      dv[k] = $signed(s1_ray_r.dir[k]) * s1_v_r[k];
      vv[k] = s1_v_r[k] * s1_v_r[k];
    end
    rr = radius_r * radius_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ray_r <= s1_ray_r;
      s2_rr_r  <= rr;
      for (int k = 0; k < 3; k++) begin
        s2_dd_r[k] <= dd[k];
        s2_dv_r[k] <= dv[k];
        s2_vv_r[k] <= vv[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // S3: a, h, c
  // --------------------------------------------------------------------------
  logic [A_W-1:0]        a_sum;
  logic signed [H_W-1:0] h_sum;
  logic signed [C_W-1:0] c_sum;
  side_t                 s3_side_r;
  logic signed [C_W-1:0] s3_c_r;

  always_comb begin
    a_sum = s2_dd_r[0] + s2_dd_r[1] + s2_dd_r[2];
    h_sum = s2_dv_r[0] + s2_dv_r[1] + s2_dv_r[2];
    c_sum = s2_vv_r[0] + s2_vv_r[1] + s2_vv_r[2] - $signed({1'b0, s2_rr_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.ray  <= s2_ray_r;
      s3_side_r.a    <= a_sum;
      s3_side_r.h    <= h_sum;
      s3_side_r.miss <= 1'b0;
      s3_c_r         <= c_sum;
    end
  end

  // --------------------------------------------------------------------------
  // S4: partial products of h*h and a*c
  // --------------------------------------------------------------------------
  logic signed [32:0]     hh;
  logic [32:0]            hl;
  logic [31:0]            ah;
  logic [31:0]            al;
  logic signed [32:0]     ch;
  logic [33:0]            cl;
  logic signed [PP_W-1:0] p_hh;
  logic signed [PP_W:0]   p_hl;
  logic [PP_W-1:0]        p_ll;
  logic signed [PP_W-1:0] p_ahch;
  logic [PP_W-1:0]        p_ahcl;
  logic signed [PP_W-1:0] p_alch;
  logic [PP_W-1:0]        p_alcl;
  side_t                  s4_side_r;
  logic signed [PP_W-1:0] s4_hh_r;
  logic signed [PP_W:0]   s4_hl_r;
  logic [PP_W-1:0]        s4_ll_r;
  logic signed [PP_W-1:0] s4_ahch_r;
  logic [PP_W-1:0]        s4_ahcl_r;
  logic signed [PP_W-1:0] s4_alch_r;
  logic [PP_W-1:0]        s4_alcl_r;

  always_comb begin
    hh     = s3_side_r.h[H_W-1:33];
    hl     = s3_side_r.h[32:0];
    ah     = s3_side_r.a[A_W-1:32];
    al     = s3_side_r.a[31:0];
    ch     = s3_c_r[C_W-1:34];
    cl     = s3_c_r[33:0];
    p_hh   = hh * hh;
    p_hl   = hh * $signed({1'b0, hl});
    p_ll   = hl * hl;
    p_ahch = $signed({1'b0, ah}) * ch;
    p_ahcl = ah * cl;
    p_alch = $signed({1'b0, al}) * ch;
    p_alcl = al * cl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s3_side_r;
      s4_hh_r   <= p_hh;
      s4_hl_r   <= p_hl;
      s4_ll_r   <= p_ll;
      s4_ahch_r <= p_ahch;
      s4_ahcl_r <= p_ahcl;
      s4_alch_r <= p_alch;
      s4_alcl_r <= p_alcl;
    end
  end

  // --------------------------------------------------------------------------
  // S5: assemble h*h and a*c
  // --------------------------------------------------------------------------
  logic signed [DISC_W-1:0] hsq;
  logic signed [DISC_W-1:0] ac;
  side_t                    s5_side_r;
  logic signed [DISC_W-1:0] s5_hsq_r;
  logic signed [DISC_W-1:0] s5_ac_r;

  always_comb begin
    hsq = (DISC_W'(s4_hh_r) <<< 66) + (DISC_W'(s4_hl_r) <<< 34)
        + DISC_W'($signed({1'b0, s4_ll_r}));
    ac  = (DISC_W'(s4_ahch_r) <<< 66) + (DISC_W'($signed({1'b0, s4_ahcl_r})) <<< 32)
        + (DISC_W'(s4_alch_r) <<< 34) + DISC_W'($signed({1'b0, s4_alcl_r}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= s4_side_r;
      s5_hsq_r  <= hsq;
      s5_ac_r   <= ac;
    end
  end

  // --------------------------------------------------------------------------
  // S6: discriminant and early miss
  // --------------------------------------------------------------------------
  logic signed [DISC_W-1:0] disc;
  side_t                    s6_side_nxt;
  side_t                    s6_side_r;
  logic [RADICAND_W-1:0]    s6_rad_r;

  assign disc = s5_hsq_r - s5_ac_r;

  always_comb begin
    s6_side_nxt      = s5_side_r;
    s6_side_nxt.miss = (s5_side_r.a == '0) || disc[DISC_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r <= s6_side_nxt;
      s6_rad_r  <= disc[RADICAND_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one result bit per stage
  // --------------------------------------------------------------------------
  side_t                 sq_side_r [SQ_N];
  logic [RADICAND_W-1:0] sq_rad_r  [SQ_N];
  logic [SQ_REM_W-1:0]   sq_rem_r  [SQ_N];
  logic [ROOT_W-1:0]     sq_root_r [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    side_t                 side_in;
    logic [RADICAND_W-1:0] rad_in;
    logic [SQ_REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]     root_in;
    logic [SQ_REM_W-1:0]   rem_sh;
    logic [SQ_REM_W-1:0]   trial;
    logic                  ge;

    if (i == 0) begin : g_first
      assign side_in = s6_side_r;
      assign rad_in  = s6_rad_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign side_in = sq_side_r[i-1];
      assign rad_in  = sq_rad_r[i-1];
      assign rem_in  = sq_rem_r[i-1];
      assign root_in = sq_root_r[i-1];
    end

    // bring down two radicand bits, try (root << 2) | 1
    assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[RADICAND_W-1-2*i -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[i] <= side_in;
        sq_rad_r[i]  <= rad_in;
        sq_rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_r[i] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // N1: both numerators -h - s and -h + s
  // --------------------------------------------------------------------------
  side_t                   n1_side_r;
  logic signed [NUM_W-1:0] nh;
  logic signed [NUM_W-1:0] n_lo;
  logic signed [NUM_W-1:0] n_hi;
  logic signed [NUM_W-1:0] n1_lo_r;
  logic signed [NUM_W-1:0] n1_hi_r;

  always_comb begin
    nh   = -$signed(sq_side_r[SQ_N-1].h);
    n_lo = nh - $signed({1'b0, sq_root_r[SQ_N-1]});
    n_hi = nh + $signed({1'b0, sq_root_r[SQ_N-1]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_side_r <= sq_side_r[SQ_N-1];
      n1_lo_r   <= n_lo;
      n1_hi_r   <= n_hi;
    end
  end

  // --------------------------------------------------------------------------
  // N2: keep the nearer root with t > 1
  // --------------------------------------------------------------------------
  logic              lo_ok;
  logic              hi_ok;
  side_t             n2_side_nxt;
  side_t             n2_side_r;
  logic [NUMU_W-1:0] n2_num_r;

  assign lo_ok = n1_lo_r > $signed({1'b0, n1_side_r.a});
  assign hi_ok = n1_hi_r > $signed({1'b0, n1_side_r.a});

  always_comb begin
    n2_side_nxt      = n1_side_r;
    n2_side_nxt.miss = n1_side_r.miss || (!lo_ok && !hi_ok);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_side_r <= n2_side_nxt;
      n2_num_r  <= lo_ok ? n1_lo_r[NUMU_W-1:0] : n1_hi_r[NUMU_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Divider: t = (num << FRAC_BITS) / a, one quotient bit per stage
  // --------------------------------------------------------------------------
  side_t             dv_side_r [QW];
  logic [NUMU_W-1:0] dv_num_r  [QW];
  logic [A_W-1:0]    dv_rem_r  [QW];
  logic [QW-1:0]     dv_q_r    [QW];

  for (genvar i = 0; i < QW; i++) begin : g_dv
    side_t             side_in;
    logic [NUMU_W-1:0] num_in;
    logic [A_W-1:0]    rem_in;
    logic [QW-1:0]     q_in;
    logic              nbit;
    logic [A_W:0]      trial;
    logic [A_W:0]      diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign side_in = n2_side_r;
      assign num_in  = n2_num_r;
      assign rem_in  = '0;
      assign q_in    = '0;
    end else begin : g_next
      assign side_in = dv_side_r[i-1];
      assign num_in  = dv_num_r[i-1];
      assign rem_in  = dv_rem_r[i-1];
      assign q_in    = dv_q_r[i-1];
    end

    // dividend bits past the numerator are the zero fraction bits
    if (i < NUMU_W) begin : g_nbit
      assign nbit = num_in[NUMU_W-1-i];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    assign trial = {rem_in, nbit};
    assign diff  = trial - {1'b0, side_in.a};
    assign ge    = trial >= {1'b0, side_in.a};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side_r[i] <= side_in;
        dv_num_r[i]  <= num_in;
        dv_rem_r[i]  <= ge ? diff[A_W-1:0] : trial[A_W-1:0];
        dv_q_r[i]    <= {q_in[QW-2:0], ge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // M1: t * dir, split into 32-bit limbs of t
  // --------------------------------------------------------------------------
  logic [QL*32-1:0]       tq_pad;
  logic signed [MP_W-1:0] mp [3][QL];
  side_t                  m1_side_r;
  logic signed [MP_W-1:0] m1_p_r [3][QL];

  assign tq_pad = (QL*32)'(dv_q_r[QW-1]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < QL; j++) begin
        mp[k][j] = $signed({1'b0, tq_pad[32*j +: 32]})
                 * $signed(dv_side_r[QW-1].ray.dir[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_side_r <= dv_side_r[QW-1];
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < QL; j++) begin
          m1_p_r[k][j] <= mp[k][j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // M2: sum the limb products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] msum [3];
  side_t                m2_side_r;
  logic signed [PW-1:0] m2_sum_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      msum[k] = '0;
      for (int j = 0; j < QL; j++) begin
        msum[k] = msum[k] + (PW'(m1_p_r[k][j]) <<< (32 * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_side_r <= m1_side_r;
      for (int k = 0; k < 3; k++) begin
        m2_sum_r[k] <= msum[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // M3: scale, add origin, saturate; output register
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]      tot [3];
  logic signed [COORD_W-1:0] pt  [3];
  logic                      out_hit_r;
  logic signed [COORD_W-1:0] out_pt_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot[k] = (m2_sum_r[k] >>> FRAC_BITS) + $signed(m2_side_r.ray.org[k]);
      if (tot[k] > PW'(COORD_MAX)) begin
        pt[k] = COORD_MAX;
      end else if (tot[k] < PW'(COORD_MIN)) begin
        pt[k] = COORD_MIN;
      end else begin
        pt[k] = tot[k][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= !m2_side_r.miss;
      for (int k = 0; k < 3; k++) begin
        out_pt_r[k] <= m2_side_r.miss ? '0 : pt[k];
      end
    end
  end

  assign out_hit   = out_hit_r;
  assign out_hit_x = out_pt_r[0];
  assign out_hit_y = out_pt_r[1];
  assign out_hit_z = out_pt_r[2];

endmodule

[rtl/rsi_checker.sv]
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks of the ray/sphere intersection core.
// ----------------------------------------------------------------------------
module rsi_checker
  import rsi_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_hit,
  input logic signed [COORD_W-1:0] out_hit_x,
  input logic signed [COORD_W-1:0] out_hit_y,
  input logic signed [COORD_W-1:0] out_hit_z
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_hit_x)
      && $stable(out_hit_y) && $stable(out_hit_z))
    else $error("result changed while stalled");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_x == 0 && out_hit_y == 0 && out_hit_z == 0)
    else $error("miss with nonzero point");

  // input only stalls under output back-pressure
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ray_sphere_intersect_core rsi_checker u_rsi_checker (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_sphere_intersect_core: rays are traced by a wide
// integer predictor and every result transaction is compared in order, over
// several sphere settings with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import rsi_pkg::*;

  localparam int FB       = 16;
  localparam int WW       = 192;
  localparam int LATENCY  = 144 + FB;
  localparam int LIMIT    = 600000;
  localparam int N_PHASES = 6;
  localparam int PER_PH   = 185;

  typedef logic signed [WW-1:0] wide_t;

  typedef struct {
    logic                      hit;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct {
    ray_t   ray;
    logic   typed;
    point_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [COORD_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [COORD_W-1:0] out_hit_x, out_hit_y, out_hit_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  // sphere as the predictor sees it
  logic signed [COORD_W-1:0] sph_c [3];
  logic [RAD_W-1:0] sph_r;

  point_t hits_due [$];
  row_t   rows [$];
  int     errors = 0;
  int     cycles = 0;
  bit     calm = 1'b0;
  bit     hold_req = 1'b0;

  ray_sphere_intersect_core #(.FRAC_BITS(FB)) i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // trace one ray against the current sphere
  function automatic point_t trace_ray(ray_t r);
    wide_t a, h, c, disc, s, cand, num, tq, o, d, v, p, sum, rr;
    point_t res;
    logic signed [COORD_W-1:0] co [3];
    res = '{1'b0, '0, '0, '0};
    a = '0;
    h = '0;
    c = '0;
    for (int k = 0; k < 3; k++) begin
      o = $signed(r.org[k]);
      d = $signed(r.dir[k]);
      v = o - wide_t'(sph_c[k]);
      a = a + d * d;
      h = h + d * v;
      c = c + v * v;
    end
    rr = wide_t'({1'b0, sph_r});
    c = c - rr * rr;
    disc = h * h - a * c;
    if (a == 0 || disc < 0) return res;
    s = '0;
    for (int i = 69; i >= 0; i--) begin
      cand = s;
      cand[i] = 1'b1;
      if (cand * cand <= disc) s = cand;
    end
    num = -h - s;
    if (!(num > a)) begin
      num = -h + s;
      if (!(num > a)) return res;
    end
    tq = (num <<< FB) / a;
    for (int k = 0; k < 3; k++) begin
      o = $signed(r.org[k]);
      d = $signed(r.dir[k]);
      p = (tq * d) >>> FB;
      sum = o + p;
      if (sum > wide_t'(COORD_MAX)) co[k] = COORD_MAX;
      else if (sum < wide_t'(COORD_MIN)) co[k] = COORD_MIN;
      else co[k] = sum[COORD_W-1:0];
    end
    res.hit = 1'b1;
    res.x = co[0];
    res.y = co[1];
    res.z = co[2];
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp32(longint val);
    if (val > 64'sd2147483647) return COORD_MAX;
    if (val < -64'sd2147483648) return COORD_MIN;
    return val[COORD_W-1:0];
  endfunction

  // random ray: mostly aimed at the sphere from outside, some noise
  function automatic ray_t make_ray();
    ray_t r;
    int mode;
    longint off, ov;
    int k_div;
    mode = $urandom_range(0, 9);
    k_div = $urandom_range(2, 40);
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0, 1: begin
          r.org[k] = $urandom;
          r.dir[k] = $urandom;
        end
        2: begin
          r.org[k] = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
          r.dir[k] = (k == 2) ? '0 : $signed($urandom_range(0, 2 ** 18)) - 2 ** 17;
        end
        default: begin
          off = longint'($signed($urandom_range(0, 2 ** 25))) - 2 ** 24;
          ov = longint'(sph_c[k]) + off;
          r.org[k] = clamp32(ov);
          r.dir[k] = clamp32((longint'(sph_c[k]) - longint'($signed(r.org[k]))) / k_div
                             + longint'($signed($urandom_range(0, 2 ** 12))) - 2 ** 11);
        end
      endcase
    end
    if (mode == 3) r.dir = '0;
    return r;
  endfunction

  task automatic send_ray(ray_t r);
    @(negedge clk);
    in_valid = 1'b1;
    in_origin_x = r.org[0];
    in_origin_y = r.org[1];
    in_origin_z = r.org[2];
    in_dir_x = r.dir[0];
    in_dir_y = r.dir[1];
    in_dir_z = r.dir[2];
    do @(posedge clk); while (in_stall);
    hits_due.push_back(trace_ray(r));
    // random idle burst on the sender side
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_X: sph_c[0] = val;
      CFG_CENTER_Y: sph_c[1] = val;
      CFG_CENTER_Z: sph_c[2] = val;
      CFG_RADIUS:   sph_r = val[RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (hits_due.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic add_row(int ox, int oy, int oz, int dx, int dy, int dz,
                         logic typed, logic hit, int hx, int hy, int hz);
    row_t w;
    w.ray.org[0] = ox;
    w.ray.org[1] = oy;
    w.ray.org[2] = oz;
    w.ray.dir[0] = dx;
    w.ray.dir[1] = dy;
    w.ray.dir[2] = dz;
    w.typed = typed;
    w.want = '{hit, hx, hy, hz};
    rows.push_back(w);
  endtask

  // receiver back-pressure
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        for (int n = 0; n < 400; n++) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 20) == 0) begin
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end
    end
  end

  // result transaction check
  always @(posedge clk) begin
    point_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (hits_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result hit=%0b (%0d %0d %0d)", $time,
                 out_hit, out_hit_x, out_hit_y, out_hit_z);
      end else begin
        w = hits_due.pop_front();
        if (out_hit !== w.hit || out_hit_x !== w.x || out_hit_y !== w.y ||
            out_hit_z !== w.z) begin
          errors++;
          $display("%0t: mismatch expected hit=%0b (%0d %0d %0d) actual hit=%0b (%0d %0d %0d)",
                   $time, w.hit, w.x, w.y, w.z, out_hit, out_hit_x, out_hit_y, out_hit_z);
        end
      end
    end
  end

  initial begin
    point_t p;
    sph_c = '{0, 0, 0};
    sph_r = RADIUS_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rays against the unit sphere at the origin
    add_row(0, 0, -5 * 65536, 0, 0, 65536, 1, 1, 0, 0, -65536);      // hit at t = 4
    add_row(0, 0, -98304, 0, 0, 65536, 1, 1, 0, 0, 65536);           // near root <= 1
    add_row(0, 0, -98304, 0, 0, 4 * 65536, 1, 0, 0, 0, 0);           // both roots <= 1
    add_row(0, 5 * 65536, -5 * 65536, 0, 0, 65536, 1, 0, 0, 0, 0);   // disc < 0
    add_row(123, -456, 789, 0, 0, 0, 1, 0, 0, 0, 0);                  // zero direction
    add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(32'h80000000, 32'h80000000, 32'h80000000,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0);
    add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0);
    add_row(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0);
    add_row(0, -10 * 65536, 0, 0, 65536, 0, 0, 0, 0, 0, 0);
    add_row(-3 * 65536, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(-3 * 65536, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(-9 * 65536, 65535, 0, 3 * 65536, 0, 0, 0, 0, 0, 0, 0);   // grazing
    add_row(-32768, -32768, -32768, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000,
            0, 0, 0, 0, 0);
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        p = trace_ray(rows[i].ray);
        if (p.hit !== rows[i].want.hit || p.x !== rows[i].want.x ||
            p.y !== rows[i].want.y || p.z !== rows[i].want.z) begin
          errors++;
          $display("%0t: predictor row %0d expected hit=%0b (%0d %0d %0d) actual hit=%0b (%0d %0d %0d)",
                   $time, i, rows[i].want.hit, rows[i].want.x, rows[i].want.y,
                   rows[i].want.z, p.hit, p.x, p.y, p.z);
        end
      end
      send_ray(rows[i].ray);
    end

    // random phases, each under its own sphere
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(CFG_CENTER_X, 32'h7FFFFFFF);
          write_reg(CFG_CENTER_Y, 32'h80000000);
          write_reg(CFG_CENTER_Z, 32'h0);
          write_reg(CFG_RADIUS, 32'h7FFFFFFF);
        end
        2: begin
          write_reg(CFG_CENTER_X, 32'h80000000);
          write_reg(CFG_CENTER_Y, 32'h7FFFFFFF);
          write_reg(CFG_CENTER_Z, 32'h80000000);
          write_reg(CFG_RADIUS, 32'h0);
        end
        0: ;
        default: begin
          write_reg(CFG_CENTER_X, $signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
          write_reg(CFG_CENTER_Y, $signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
          write_reg(CFG_CENTER_Z, $urandom);
          write_reg(CFG_RADIUS, $urandom_range(1, 2 ** 24));
        end
      endcase
      if (ph == 3) hold_req = 1'b1;
      if (ph == N_PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PER_PH; n++) send_ray(make_ray());
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (hits_due.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rsi_pkg.sv
rtl/ray_sphere_intersect_core.sv
rtl/rsi_checker.sv
tb/tb.sv
